### sv/urxf_pkg.sv
// ============================================================================
// urxf_pkg
// Shared constants, operation codes and types of the UART receiver with FIFO.
// ============================================================================
`default_nettype none

package urxf_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int BYTE_W     = 8;
    localparam int ENTRY_W    = BYTE_W + 1;
    localparam int BT_W       = 16;
    localparam int TICK_W     = 18;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BT_W;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NINTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 2'd3;

    typedef struct packed {
        logic             rd_hit;
        logic [PTR_W-1:0] fill;
        logic             ovf;
        logic             stored;
    } t_stat;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_ninth;
        logic              read_valid;
        logic [PTR_W-1:0]  fill_level;
        logic              overflow_seen;
        logic              byte_stored;
    } t_result;

endpackage

`default_nettype wire

### sv/urxf_in_if.sv
// ============================================================================
// urxf_in_if
// Input channel: operation code and sampled line level per beat.
// ============================================================================
`default_nettype none

interface urxf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       line_level;

    modport source (output valid, output op, output line_level, input ready);
    modport sink   (input valid, input op, input line_level, output ready);
endinterface

`default_nettype wire

### sv/urxf_out_if.sv
// ============================================================================
// urxf_out_if
// Output channel: one result beat per input beat.
// ============================================================================
`default_nettype none

interface urxf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_ninth;
    logic       read_valid;
    logic [5:0] fill_level;
    logic       overflow_seen;
    logic       byte_stored;

    modport source (
        output valid, output rx_byte, output rx_ninth, output read_valid,
        output fill_level, output overflow_seen, output byte_stored, input ready
    );
    modport sink (
        input valid, input rx_byte, input rx_ninth, input read_valid,
        input fill_level, input overflow_seen, input byte_stored, output ready
    );
endinterface

`default_nettype wire

### sv/urxf_ram.sv
// ============================================================================
// urxf_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module urxf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/urxf_ctrl.sv
// ============================================================================
// urxf_ctrl
// Config registers, serial frame receiver and FIFO pointer control.
// ============================================================================
`default_nettype none

module urxf_ctrl
    import urxf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_step,
    input  wire logic [1:0]            i_op,
    input  wire logic                  i_line,
    output logic                       o_ram_we,
    output logic [PTR_W-1:0]           o_ram_waddr,
    output logic [ENTRY_W-1:0]         o_ram_wdata,
    output logic                       o_ram_re,
    output logic [PTR_W-1:0]           o_ram_raddr,
    output t_stat                      o_stat
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_PARITY = 2'd2;
    localparam logic [1:0] PH_GUARD  = 2'd3;

    logic [BT_W-1:0]    r_bit_ticks;
    logic               r_ninth_en;
    logic               r_parity_en;
    logic [1:0]         r_stop_bits;

    logic [1:0]         r_phase,  n_phase;
    logic [TICK_W-1:0]  r_tick,   n_tick;
    logic [IDX_W-1:0]   r_idx,    n_idx;
    logic [ENTRY_W-1:0] r_shift,  n_shift;
    logic [PTR_W-1:0]   r_head,   n_head;
    logic [PTR_W-1:0]   r_tail,   n_tail;
    logic               r_ovf,    n_ovf;

    logic [TICK_W-1:0]  bt_ext;
    logic [TICK_W-1:0]  bt3;
    logic [TICK_W-1:0]  start_ticks;
    logic [TICK_W-1:0]  stop_ticks;
    logic [TICK_W-1:0]  guard_ticks;
    logic [ENTRY_W-1:0] shifted;
    logic [ENTRY_W-1:0] word;
    logic [PTR_W-1:0]   tail_inc;
    logic               frame_done;
    logic               stored;
    logic               rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks <= BT_W'(16);
            r_ninth_en  <= 1'b0;
            r_parity_en <= 1'b0;
            r_stop_bits <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIT_TICKS: r_bit_ticks <= i_cfg_data;
                CFG_NINTH:     r_ninth_en  <= i_cfg_data[0];
                CFG_PARITY:    r_parity_en <= i_cfg_data[0];
                CFG_STOP:      r_stop_bits <= i_cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    // delay loads
    assign bt_ext      = TICK_W'(r_bit_ticks);
    assign bt3         = bt_ext + {bt_ext[TICK_W-2:0], 1'b0};
    assign start_ticks = bt_ext + (bt_ext >> 1);

    always_comb begin
        case (r_stop_bits)
            2'd0:    stop_ticks = '0;
            2'd1:    stop_ticks = bt_ext;
            2'd2:    stop_ticks = {bt_ext[TICK_W-2:0], 1'b0};
            default: stop_ticks = bt3;
        endcase
    end

    assign guard_ticks = (bt3 >> 2) + stop_ticks;
    assign tail_inc    = r_tail + PTR_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_idx      = r_idx;
        n_shift    = r_shift;
        n_head     = r_head;
        n_tail     = r_tail;
        n_ovf      = r_ovf;
        stored     = 1'b0;
        rd_hit     = 1'b0;
        frame_done = 1'b0;
        shifted    = r_shift;
        word       = r_shift;
        if (i_line && (r_idx < IDX_W'(ENTRY_W))) begin
            shifted = r_shift | (ENTRY_W'(1) << r_idx);
        end
        if (i_step) begin
            case (i_op)
                OP_TICK: begin
                    if (r_phase == PH_IDLE) begin
                        if (!i_line) begin
                            n_phase = PH_DATA;
                            n_tick  = start_ticks;
                            n_idx   = '0;
                            n_shift = '0;
                        end
                    end else if (r_tick > TICK_W'(1)) begin
                        n_tick = r_tick - TICK_W'(1);
                    end else begin
                        unique case (r_phase)
                            PH_DATA: begin
                                n_shift = shifted;
                                n_idx   = r_idx + IDX_W'(1);
                                frame_done = r_ninth_en ? (n_idx >= IDX_W'(9))
                                                        : (n_idx >= IDX_W'(8));
                                if (frame_done) begin
                                    word = r_ninth_en ? shifted
                                                      : {1'b0, shifted[BYTE_W-1:0]};
                                    if (tail_inc == r_head) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        stored = 1'b1;
                                        n_tail = tail_inc;
                                    end
                                    if (r_parity_en) begin
                                        n_phase = PH_PARITY;
                                        n_tick  = bt_ext;
                                    end else begin
                                        n_phase = PH_GUARD;
                                        n_tick  = guard_ticks;
                                    end
                                end else begin
                                    n_tick = bt_ext;
                                end
                            end
                            PH_PARITY: begin
                                n_phase = PH_GUARD;
                                n_tick  = guard_ticks;
                            end
                            PH_GUARD: begin
                                n_phase = PH_IDLE;
                                n_tick  = '0;
                            end
                            default: ;
                        endcase
                    end
                end
                OP_READ, OP_PEEK: begin
                    if (r_head != r_tail) begin
                        rd_hit = 1'b1;
                        if (i_op == OP_READ) begin
                            n_head = r_head + PTR_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_idx   <= '0;
            r_shift <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ovf   <= n_ovf;
        end
    end

    assign o_ram_we    = stored;
    assign o_ram_waddr = r_tail;
    assign o_ram_wdata = word;
    assign o_ram_re    = i_step;
    assign o_ram_raddr = r_head;

    assign o_stat.rd_hit = rd_hit;
    assign o_stat.fill   = n_tail - n_head;
    assign o_stat.ovf    = n_ovf;
    assign o_stat.stored = stored;

endmodule

`default_nettype wire

### sv/urxf_skid.sv
// ============================================================================
// urxf_skid
// Two-entry output skid buffer with a registered upstream ready.
// ============================================================================
`default_nettype none

module urxf_skid
    import urxf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_up_valid,
    output logic         o_up_ready,
    input  wire t_result i_up_data,
    output logic         o_dn_valid,
    input  wire logic    i_dn_ready,
    output t_result      o_dn_data
);

    logic    r_o_vld;
    logic    r_sk_vld;
    t_result r_o;
    t_result r_sk;

    assign o_up_ready = !r_sk_vld;
    assign o_dn_valid = r_o_vld;
    assign o_dn_data  = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (i_dn_ready || !r_o_vld) begin
            if (r_sk_vld) begin
                r_o_vld  <= 1'b1;
                r_sk_vld <= 1'b0;
            end else begin
                r_o_vld <= i_up_valid;
            end
        end else if (i_up_valid && !r_sk_vld) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dn_ready || !r_o_vld) begin
            r_o <= r_sk_vld ? r_sk : i_up_data;
        end else if (i_up_valid && !r_sk_vld) begin
            r_sk <= i_up_data;
        end
    end

endmodule

`default_nettype wire

### sv/uart_rx_with_fifo_core.sv
// ============================================================================
// uart_rx_with_fifo_core
// UART receiver with a 64-entry receive FIFO, one result beat per input beat.
// ============================================================================
// Each input beat is a line sample tick, a read (pop), a peek or a no-op, and
// gives exactly one result beat. A beat is taken every clock while the output
// side keeps up: the FIFO read, the frame receiver update and the pointer
// update all happen in the accept cycle, the RAM read data lands in the next
// cycle in a result stage, and a two-entry skid buffer drives the output, so
// a stall on the output costs no throughput until both skid entries are full.
// The FIFO holds up to 63 bytes with their ninth bits; a byte completed on a
// full FIFO is dropped and sets a sticky overflow flag. Configuration writes
// take effect on the next clock and should be made while no beats are in
// flight.
`default_nettype none

module uart_rx_with_fifo_core
    import urxf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    urxf_in_if.sink                    i_in,
    urxf_out_if.source                 o_out
);

    logic               step;
    logic               pipe_ready;
    logic               sk_ready;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_q;
    t_stat              stat;
    t_stat              r_p_stat;
    logic               r_p_vld;
    t_result            p_res;
    t_result            dn_res;

    assign pipe_ready = !r_p_vld || sk_ready;
    assign i_in.ready = pipe_ready;
    assign step       = i_in.valid && pipe_ready;

    urxf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_op        (i_in.op),
        .i_line      (i_in.line_level),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_stat      (stat)
    );

    urxf_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // result stage, aligned with the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (pipe_ready) begin
            r_p_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_p_stat <= stat;
        end
    end

    assign p_res.rx_byte       = r_p_stat.rd_hit ? ram_q[BYTE_W-1:0] : '0;
    assign p_res.rx_ninth      = r_p_stat.rd_hit ? ram_q[BYTE_W] : 1'b0;
    assign p_res.read_valid    = r_p_stat.rd_hit;
    assign p_res.fill_level    = r_p_stat.fill;
    assign p_res.overflow_seen = r_p_stat.ovf;
    assign p_res.byte_stored   = r_p_stat.stored;

    urxf_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (r_p_vld),
        .o_up_ready (sk_ready),
        .i_up_data  (p_res),
        .o_dn_valid (o_out.valid),
        .i_dn_ready (o_out.ready),
        .o_dn_data  (dn_res)
    );

    assign o_out.rx_byte       = dn_res.rx_byte;
    assign o_out.rx_ninth      = dn_res.rx_ninth;
    assign o_out.read_valid    = dn_res.read_valid;
    assign o_out.fill_level    = dn_res.fill_level;
    assign o_out.overflow_seen = dn_res.overflow_seen;
    assign o_out.byte_stored   = dn_res.byte_stored;

    a_p_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld && !sk_ready |=> r_p_vld && $stable(r_p_stat))
        else $error("result stage lost a beat under stall");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld && r_p_stat.ovf && sk_ready |=> !r_p_vld || r_p_stat.ovf)
        else $error("overflow flag cleared");

    a_write_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> step && stat.stored)
        else $error("FIFO write without a stored byte");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && stat.rd_hit |-> !ram_we)
        else $error("push and pop in one beat");

endmodule

`default_nettype wire

### verif/uart_rx_with_fifo_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// uart_rx_with_fifo_core_test
// Self-checking bench: serial frames, FIFO reads and peeks against a predictor.
// ============================================================================
// Line-sample ticks carry well-formed frames, broken frames and noise. Reads
// and peeks are mixed in, and the FIFO is filled to overflow. A scoreboard
// keeps its own model of the receiver and the FIFO, builds one expected beat
// per accepted input beat and compares each result beat field by field.
// Short fixed cases run first: the reset settings, one-tick bit periods and
// dropping the ninth bit mid-frame. Random traffic then runs under changing
// settings and two stall patterns, and back-to-back frames without stalls
// run the FIFO past full.

import urxf_pkg::*;

class rx_fifo_scoreboard;
    typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_PARITY, RX_GUARD} rx_phase_e;

    logic [BT_W-1:0]    bit_ticks;
    logic               ninth_en;
    logic               parity_en;
    logic [1:0]         stop_bits;

    rx_phase_e          phase;
    logic [TICK_W-1:0]  tick_cnt;
    logic [IDX_W-1:0]   bit_idx;
    logic [ENTRY_W-1:0] shift_word;
    logic [ENTRY_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic               ovf;

    t_result            due_results[$];
    int                 errors;
    int                 checked;

    function new();
        bit_ticks  = 16;
        ninth_en   = 1'b0;
        parity_en  = 1'b0;
        stop_bits  = 2'd1;
        phase      = RX_IDLE;
        tick_cnt   = '0;
        bit_idx    = '0;
        shift_word = '0;
        rd_ptr     = '0;
        wr_ptr     = '0;
        ovf        = 1'b0;
        errors     = 0;
        checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BIT_TICKS: bit_ticks = data;
            CFG_NINTH:     ninth_en  = data[0];
            CFG_PARITY:    parity_en = data[0];
            CFG_STOP:      stop_bits = data[1:0];
            default: ;
        endcase
    endfunction

    function logic [TICK_W-1:0] guard_len();
        int unsigned bt;
        bt = bit_ticks;
        return TICK_W'(((bt * 3) >> 2) + stop_bits * bt);
    endfunction

    function logic push_word(logic [ENTRY_W-1:0] word);
        logic [PTR_W-1:0] nxt;
        nxt = wr_ptr + 1'b1;
        if (nxt == rd_ptr) begin
            ovf = 1'b1;
            return 1'b0;
        end
        fifo_mem[wr_ptr] = word;
        wr_ptr = nxt;
        return 1'b1;
    endfunction

    function logic step_receiver(logic line);
        logic        stored;
        int unsigned bt;
        stored = 1'b0;
        bt = bit_ticks;
        if (phase == RX_IDLE) begin
            if (!line) begin
                phase      = RX_DATA;
                tick_cnt   = TICK_W'(bt + (bt >> 1));
                bit_idx    = '0;
                shift_word = '0;
            end
            return 1'b0;
        end
        if (tick_cnt > 1) begin
            tick_cnt = tick_cnt - 1'b1;
            return 1'b0;
        end
        case (phase)
            RX_DATA: begin
                if (line && bit_idx < 9)
                    shift_word[bit_idx] = 1'b1;
                bit_idx = bit_idx + 1'b1;
                if (bit_idx >= 8 + ninth_en) begin
                    stored = push_word(ninth_en ? shift_word : {1'b0, shift_word[7:0]});
                    if (parity_en) begin
                        phase    = RX_PARITY;
                        tick_cnt = TICK_W'(bt);
                    end else begin
                        phase    = RX_GUARD;
                        tick_cnt = guard_len();
                    end
                end else begin
                    tick_cnt = TICK_W'(bt);
                end
            end
            RX_PARITY: begin
                phase    = RX_GUARD;
                tick_cnt = guard_len();
            end
            default: begin
                phase    = RX_IDLE;
                tick_cnt = '0;
            end
        endcase
        return stored;
    endfunction

    function void note_input(logic [1:0] op, logic line);
        t_result r;
        r = '0;
        case (op)
            OP_TICK: r.byte_stored = step_receiver(line);
            OP_READ, OP_PEEK: begin
                if (rd_ptr != wr_ptr) begin
                    r.rx_byte    = fifo_mem[rd_ptr][7:0];
                    r.rx_ninth   = fifo_mem[rd_ptr][8];
                    r.read_valid = 1'b1;
                    if (op == OP_READ)
                        rd_ptr = rd_ptr + 1'b1;
                end
            end
            default: ;
        endcase
        r.fill_level    = wr_ptr - rd_ptr;
        r.overflow_seen = ovf;
        due_results.push_back(r);
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    task report_mismatch(string msg);
        errors++;
        // keep the log bounded if the block is badly broken
        if (errors <= 200)
            $display("MISMATCH result %0d: %s", checked, msg);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task check_result(t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        check_field("rx_byte", got.rx_byte, want.rx_byte);
        check_field("rx_ninth", got.rx_ninth, want.rx_ninth);
        check_field("read_valid", got.read_valid, want.read_valid);
        check_field("fill_level", got.fill_level, want.fill_level);
        check_field("overflow_seen", got.overflow_seen, want.overflow_seen);
        check_field("byte_stored", got.byte_stored, want.byte_stored);
        checked++;
    endtask
endclass

module uart_rx_with_fifo_core_test;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SUB_BEATS     = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    urxf_in_if  in_ch();
    urxf_out_if out_ch();

    uart_rx_with_fifo_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    rx_fifo_scoreboard sb;
    int src_idle_pct = 0;
    int rx_idle_pct  = 0;
    int beats_sent   = 0;
    int cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: check accepted beats, stall at random
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(t_result'{
                    rx_byte:       out_ch.rx_byte,
                    rx_ninth:      out_ch.rx_ninth,
                    read_valid:    out_ch.read_valid,
                    fill_level:    out_ch.fill_level,
                    overflow_seen: out_ch.overflow_seen,
                    byte_stored:   out_ch.byte_stored});
            out_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task send_beat(logic [1:0] op, logic line);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.line_level <= line;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(op, line);
        beats_sent++;
    endtask

    task send_level(logic lvl, int unsigned n, bit interleave);
        repeat (n) begin
            if (interleave && $urandom_range(99) < 8)
                send_beat($urandom_range(1) ? OP_READ : OP_PEEK, 1'($urandom_range(1)));
            send_beat(OP_TICK, lvl);
        end
    endtask

    task send_frame(logic [ENTRY_W-1:0] word, bit interleave);
        int unsigned bt;
        int unsigned slot;
        int unsigned hold;
        bt   = sb.bit_ticks;
        slot = (bt < 2) ? 1 : bt;
        send_level(1'b0, slot, interleave);
        for (int i = 0; i < 8 + sb.ninth_en; i++)
            send_level(word[i], slot, interleave);
        if (sb.parity_en)
            send_level(1'($urandom_range(1)), slot, interleave);
        hold = ((bt * 3) >> 2) + sb.stop_bits * bt + slot + $urandom_range(1, 4);
        send_level(1'b1, hold, interleave);
    endtask

    // one-tick bit periods, no parity, no stop bits: one idle tick between frames
    task send_tight_frame(logic [ENTRY_W-1:0] word);
        send_beat(OP_TICK, 1'b0);
        for (int i = 0; i < 8 + sb.ninth_en; i++)
            send_beat(OP_TICK, word[i]);
        send_beat(OP_TICK, 1'b1);
    endtask

    task send_broken_frame();
        int unsigned slot;
        slot = (sb.bit_ticks < 2) ? 1 : sb.bit_ticks;
        send_level(1'b0, $urandom_range(1, slot), 1'b0);
        repeat ($urandom_range(1, 6 * slot)) send_beat(OP_TICK, 1'($urandom_range(1)));
        send_level(1'b1, $urandom_range(0, 4 * slot), 1'b0);
    endtask

    task settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task apply_config(logic [BT_W-1:0] bt, logic ninth, logic par, logic [1:0] stop);
        settle();
        write_reg(CFG_BIT_TICKS, bt);
        write_reg(CFG_NINTH, CFG_DATA_W'(ninth));
        write_reg(CFG_PARITY, CFG_DATA_W'(par));
        write_reg(CFG_STOP, CFG_DATA_W'(stop));
        i_cfg_we <= 1'b0;
    endtask

    task random_config();
        logic [BT_W-1:0] bt;
        case ($urandom_range(7))
            0:       bt = 0;
            1:       bt = 1;
            2:       bt = 2;
            3:       bt = 3;
            4:       bt = 4;
            5:       bt = 5;
            6:       bt = 7;
            default: bt = 10;
        endcase
        apply_config(bt, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     2'($urandom_range(3)));
    endtask

    task random_traffic();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            send_frame(ENTRY_W'($urandom), 1'b1);
        else if (pick < 70)
            send_broken_frame();
        else if (pick < 88)
            repeat ($urandom_range(1, 4))
                send_beat(($urandom_range(99) < 65) ? OP_READ : OP_PEEK,
                          1'($urandom_range(1)));
        else
            repeat ($urandom_range(1, 8))
                send_beat(2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    initial begin
        int start_beats;
        logic [7:0] pattern;

        sb = new();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_NOP;
        in_ch.line_level <= 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty FIFO and no-ops at reset
        send_beat(OP_READ, 1'b0);
        send_beat(OP_PEEK, 1'b1);
        send_beat(OP_NOP, 1'b0);

        // reset settings: start delay of 24 ticks, period cut to 4 before the first sample
        pattern = 8'h4A;
        send_beat(OP_TICK, 1'b0);
        send_level(1'b1, 22, 1'b0);
        settle();
        write_reg(CFG_BIT_TICKS, 16'd4);
        i_cfg_we <= 1'b0;
        send_level(pattern[0], 2, 1'b0);
        for (int i = 1; i < 8; i++)
            send_level(pattern[i], 4, 1'b0);
        send_level(1'b1, 20, 1'b0);
        send_beat(OP_PEEK, 1'b0);
        send_beat(OP_READ, 1'b1);

        // one-tick delays, ninth bit, parity skip, three stop bits
        apply_config(16'd0, 1'b1, 1'b1, 2'd3);
        send_frame(9'h1FF, 1'b0);
        send_frame(9'h000, 1'b0);
        send_beat(OP_NOP, 1'b1);
        send_beat(OP_PEEK, 1'b0);
        repeat (3) send_beat(OP_READ, 1'b0);

        // ninth bit turned off after eight bits are in
        apply_config(16'd1, 1'b1, 1'b0, 2'd0);
        pattern = 8'h3C;
        send_beat(OP_TICK, 1'b0);
        for (int i = 0; i < 8; i++)
            send_beat(OP_TICK, pattern[i]);
        settle();
        write_reg(CFG_NINTH, '0);
        i_cfg_we <= 1'b0;
        send_beat(OP_TICK, 1'b1);
        send_level(1'b1, 4, 1'b0);
        send_beat(OP_READ, 1'b0);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 66 : 0;
            rx_idle_pct  = (ph == 0) ? 66 : (ph == 1) ? 29 : 0;
            if (ph < 2) begin
                random_config();
                start_beats = beats_sent;
                while (beats_sent - start_beats < SUB_BEATS) random_traffic();
            end else begin
                // fill past capacity, then a few reads
                apply_config(16'd0, 1'b0, 1'b0, 2'd0);
                repeat (FIFO_DEPTH) send_tight_frame(ENTRY_W'($urandom));
                repeat (3) send_beat(OP_READ, 1'($urandom_range(1)));
            end
        end

        settle();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
sv/urxf_pkg.sv
sv/urxf_in_if.sv
sv/urxf_out_if.sv
sv/urxf_ram.sv
sv/urxf_ctrl.sv
sv/urxf_skid.sv
sv/uart_rx_with_fifo_core.sv
verif/uart_rx_with_fifo_core_test.sv
